>>> src/trb_pkg.sv
// Shared types, sizes and the master colour table of the tile background renderer.
// No dependencies; every other file but trb_ram imports this package.
`default_nettype none

package trb_pkg;

    localparam int SCREEN_WIDTH   = 256;
    localparam int SCREEN_HEIGHT  = 240;
    localparam int PATTERN_TILES  = 512;

    localparam int PATTERN_BYTES  = PATTERN_TILES * 16;
    localparam int TILE_W         = $clog2(PATTERN_TILES);
    localparam int PAT_BANK_DEPTH = PATTERN_BYTES / 2;
    localparam int PAT_BANK_AW    = $clog2(PAT_BANK_DEPTH);

    localparam int NAME_CELLS     = 960;
    localparam int NAME_DEPTH     = 2 * NAME_CELLS;
    localparam int NAME_AW        = $clog2(NAME_DEPTH);
    localparam int ATTR_CELLS     = 64;
    localparam int ATTR_DEPTH     = 2 * ATTR_CELLS;
    localparam int ATTR_AW        = $clog2(ATTR_DEPTH);
    localparam int TILE_ROWS      = 30;
    localparam int PAL_DEPTH      = 32;

    localparam logic [7:0] NAME_RESET = 8'h24;

    localparam int CFG_IDX_W      = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_H    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_V    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_ENABLE   = 3'd4;

    typedef enum logic [1:0] {
        OP_VWRITE  = 2'd0,
        OP_PATLOAD = 2'd1,
        OP_PIXEL   = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TILE,
        ST_SHADE
    } t_state;

    // Access to the name and attribute stores
    typedef struct packed {
        logic        wr;
        logic        rd;
        logic [13:0] addr;
        logic [7:0]  data;
        logic        phys;
        logic [4:0]  row;
        logic [4:0]  col;
    } t_vram_req;

    function automatic logic [31:0] master_argb(input logic [5:0] idx);
        logic [31:0] c;
        unique case (idx)
            6'd0:  c = 32'hFF545454;  6'd1:  c = 32'hFF001E74;
            6'd2:  c = 32'hFF081090;  6'd3:  c = 32'hFF300088;
            6'd4:  c = 32'hFF440064;  6'd5:  c = 32'hFF5C0030;
            6'd6:  c = 32'hFF540400;  6'd7:  c = 32'hFF3C1800;
            6'd8:  c = 32'hFF202A00;  6'd9:  c = 32'hFF083A00;
            6'd10: c = 32'hFF004000;  6'd11: c = 32'hFF003C00;
            6'd12: c = 32'hFF00323C;  6'd13: c = 32'hFF000000;
            6'd14: c = 32'hFF000000;  6'd15: c = 32'hFF000000;
            6'd16: c = 32'hFF989698;  6'd17: c = 32'hFF084CC4;
            6'd18: c = 32'hFF3032EC;  6'd19: c = 32'hFF5C1EE4;
            6'd20: c = 32'hFF8814B0;  6'd21: c = 32'hFFA01464;
            6'd22: c = 32'hFF982220;  6'd23: c = 32'hFF783C00;
            6'd24: c = 32'hFF545A00;  6'd25: c = 32'hFF287200;
            6'd26: c = 32'hFF087C00;  6'd27: c = 32'hFF007628;
            6'd28: c = 32'hFF006678;  6'd29: c = 32'hFF000000;
            6'd30: c = 32'hFF000000;  6'd31: c = 32'hFF000000;
            6'd32: c = 32'hFFECEEEC;  6'd33: c = 32'hFF4C9AEC;
            6'd34: c = 32'hFF7080EC;  6'd35: c = 32'hFFA06CEC;
            6'd36: c = 32'hFFD060EC;  6'd37: c = 32'hFFEC60C0;
            6'd38: c = 32'hFFEC7274;  6'd39: c = 32'hFFCC8C38;
            6'd40: c = 32'hFFB09C18;  6'd41: c = 32'hFF7CB010;
            6'd42: c = 32'hFF4CC034;  6'd43: c = 32'hFF38C878;
            6'd44: c = 32'hFF38B4CC;  6'd45: c = 32'hFF3C3C3C;
            6'd46: c = 32'hFF000000;  6'd47: c = 32'hFF000000;
            6'd48: c = 32'hFFECEEEC;  6'd49: c = 32'hFFA8CCEC;
            6'd50: c = 32'hFFBCBCEC;  6'd51: c = 32'hFFD4B2EC;
            6'd52: c = 32'hFFECAEEC;  6'd53: c = 32'hFFECAED4;
            6'd54: c = 32'hFFECB4B0;  6'd55: c = 32'hFFE4C490;
            6'd56: c = 32'hFFCCD278;  6'd57: c = 32'hFFB4DE78;
            6'd58: c = 32'hFFA8E290;  6'd59: c = 32'hFF98E2B4;
            6'd60: c = 32'hFFA0D6E4;  6'd61: c = 32'hFFA0A2A0;
            6'd62: c = 32'hFF000000;  6'd63: c = 32'hFF000000;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/trb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module trb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/trb_vram.sv
// Name and attribute stores with mirrored write decode and the clearing pass after reset.
// Depends on trb_pkg and trb_ram.
`default_nettype none

module trb_vram (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire trb_pkg::t_vram_req i_req,
    output logic [7:0]              o_tile,
    output logic [7:0]              o_attr,
    output logic                    o_clear_busy
);
    import trb_pkg::*;

    logic               r_clearing;
    logic [NAME_AW-1:0] r_clr_idx;

    logic               in_window;
    logic [9:0]         off;
    logic               is_attr;
    logic               name_we;
    logic [NAME_AW-1:0] name_waddr;
    logic [7:0]         name_wdata;
    logic [NAME_AW-1:0] name_raddr;
    logic               attr_we;
    logic [ATTR_AW-1:0] attr_waddr;
    logic [7:0]         attr_wdata;
    logic [ATTR_AW-1:0] attr_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == NAME_AW'(NAME_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        in_window = (i_req.addr[13:12] == 2'b10);
        off       = i_req.addr[9:0];
        is_attr   = (off >= 10'(NAME_CELLS));

        if (r_clearing) begin
            name_we    = 1'b1;
            name_waddr = r_clr_idx;
            name_wdata = NAME_RESET;
            attr_we    = (r_clr_idx < NAME_AW'(ATTR_DEPTH));
            attr_waddr = ATTR_AW'(r_clr_idx);
            attr_wdata = '0;
        end else begin
            // logical tables 0,1 share physical 0; 2,3 share physical 1
            name_we    = i_req.wr && in_window && !is_attr;
            name_waddr = i_req.addr[11] ? NAME_AW'(off) + NAME_AW'(NAME_CELLS)
                                        : NAME_AW'(off);
            name_wdata = i_req.data;
            attr_we    = i_req.wr && in_window && is_attr;
            attr_waddr = {i_req.addr[11], off[5:0]};
            attr_wdata = i_req.data;
        end

        name_raddr = i_req.phys ? NAME_AW'({i_req.row, i_req.col}) + NAME_AW'(NAME_CELLS)
                                : NAME_AW'({i_req.row, i_req.col});
        attr_raddr = {i_req.phys, i_req.row[4:2], i_req.col[4:2]};
    end

    trb_ram #(.WIDTH(8), .DEPTH(NAME_DEPTH)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (name_waddr),
        .i_wdata (name_wdata),
        .i_re    (i_req.rd),
        .i_raddr (name_raddr),
        .o_rdata (o_tile)
    );

    trb_ram #(.WIDTH(8), .DEPTH(ATTR_DEPTH)) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (attr_waddr),
        .i_wdata (attr_wdata),
        .i_re    (i_req.rd),
        .i_raddr (attr_raddr),
        .o_rdata (o_attr)
    );

    assign o_clear_busy = r_clearing;

endmodule

`default_nettype wire

>>> src/trb_pattern.sv
// Pattern store split into two banks on address bit 3, so both planes of a row read at once.
// Depends on trb_pkg and trb_ram.
`default_nettype none

module trb_pattern (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [13:0]               i_waddr,
    input  wire logic [7:0]                i_wdata,
    input  wire logic                      i_re,
    input  wire logic [trb_pkg::TILE_W-1:0] i_tile,
    input  wire logic [2:0]                i_fy,
    output logic      [7:0]                o_plane0,
    output logic      [7:0]                o_plane1
);
    import trb_pkg::*;

    logic                   in_range;
    logic [PAT_BANK_AW-1:0] bank_waddr;
    logic [PAT_BANK_AW-1:0] bank_raddr;

    always_comb begin
        in_range   = (i_waddr < 14'(PATTERN_BYTES));
        bank_waddr = PAT_BANK_AW'({i_waddr[13:4], i_waddr[2:0]});
        bank_raddr = PAT_BANK_AW'({i_tile, i_fy});
    end

    trb_ram #(.WIDTH(8), .DEPTH(PAT_BANK_DEPTH)) u_plane0_ram (
        .i_clk   (i_clk),
        .i_we    (i_we && in_range && !i_waddr[3]),
        .i_waddr (bank_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (bank_raddr),
        .o_rdata (o_plane0)
    );

    trb_ram #(.WIDTH(8), .DEPTH(PAT_BANK_DEPTH)) u_plane1_ram (
        .i_clk   (i_clk),
        .i_we    (i_we && in_range && i_waddr[3]),
        .i_waddr (bank_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (bank_raddr),
        .o_rdata (o_plane1)
    );

endmodule

`default_nettype wire

>>> src/tile_background_pixel_renderer_core.sv
// Tile background renderer, 2 bits per pixel. Depends on trb_pkg, trb_vram, trb_pattern.
// A pixel request reaches its registered result by name/attribute read, then pattern read,
// then palette and colour lookup, which is held until the output register is free; no new
// input is taken meanwhile, set by the chain of dependent store reads. After reset the name
// and attribute stores are cleared, one entry per cycle, over all 1920 name entries; input
// stays stalled until the pass ends. Configuration writes are taken throughout.
`default_nettype none

module tile_background_pixel_renderer_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [trb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [7:0]                        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [1:0]                        i_opcode,
    input  wire logic [13:0]                       i_address,
    input  wire logic [7:0]                        i_data,
    input  wire logic [7:0]                        i_pixel_x,
    input  wire logic [7:0]                        i_pixel_y,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [5:0]                             o_color_index,
    output logic [31:0]                            o_color_argb
);
    import trb_pkg::*;

    t_state       r_state, n_state;
    logic [7:0]   r_scroll_h, r_scroll_v;
    logic [1:0]   r_base_table;
    logic         r_pattern_hi, r_bg_enable;
    logic [5:0]   r_palette [PAL_DEPTH];

    logic [2:0]   r_fx, r_fy;
    logic         r_row_b1, r_col_b1;
    logic [1:0]   r_pal;
    logic         r_out_valid;
    logic [5:0]   r_color_index;
    logic [31:0]  r_color_argb;
    logic         n_out_load;

    t_vram_req    vreq;
    logic [7:0]   name_q, attr_q;
    logic         clear_busy;
    logic [7:0]   plane0_q, plane1_q;

    logic         accept;
    t_opcode      op;
    logic         on_screen;
    logic [8:0]   px, py;
    logic [5:0]   coarse_y;
    logic [4:0]   row;
    logic [9:0]   tile_sum;
    logic [TILE_W-1:0] tile;
    logic [2:0]   shift;
    logic [2:0]   bit_sel;
    logic [1:0]   pix;
    logic [4:0]   pal_idx;
    logic [5:0]   color_idx;
    logic         pal_we;
    logic [4:0]   pal_waddr;

    always_comb begin
        accept    = i_in_valid && !o_in_stall;
        op        = t_opcode'(i_opcode);
        on_screen = ({1'b0, i_pixel_x} < 9'(SCREEN_WIDTH))
                 && ({1'b0, i_pixel_y} < 9'(SCREEN_HEIGHT));

        px       = {1'b0, i_pixel_x} + {1'b0, r_scroll_h};
        py       = {1'b0, i_pixel_y} + {1'b0, r_scroll_v};
        coarse_y = py[8:3];
        priority if (coarse_y >= 6'(2 * TILE_ROWS)) begin
            row = 5'(coarse_y - 6'(2 * TILE_ROWS));
        end else if (coarse_y >= 6'(TILE_ROWS)) begin
            row = 5'(coarse_y - 6'(TILE_ROWS));
        end else begin
            row = 5'(coarse_y);
        end

        vreq.wr   = accept && (op == OP_VWRITE);
        vreq.rd   = accept && (op == OP_PIXEL) && on_screen;
        vreq.addr = i_address;
        vreq.data = i_data;
        // horizontal wrap only flips the low table bit, which mirroring drops
        vreq.phys = r_base_table[1] ^ (coarse_y >= 6'(TILE_ROWS));
        vreq.row  = row;
        vreq.col  = px[7:3];

        // palette window 0x3F00-0x3F1F, sprite entry 0 of each group folds down
        pal_we    = accept && (op == OP_VWRITE) && (i_address[13:5] == 9'h1F8);
        pal_waddr = i_address[4:0];
        if (pal_waddr[4] && (pal_waddr[1:0] == 2'b00)) begin
            pal_waddr[4] = 1'b0;
        end

        tile_sum = {2'b00, name_q} + (r_pattern_hi ? 10'd256 : 10'd0);
        if (tile_sum >= 10'(PATTERN_TILES)) begin
            tile_sum = tile_sum - 10'(PATTERN_TILES);
        end
        tile  = TILE_W'(tile_sum);
        shift = {r_row_b1, r_col_b1, 1'b0};

        bit_sel   = 3'd7 - r_fx;
        pix       = {plane1_q[bit_sel], plane0_q[bit_sel]};
        pal_idx   = (!r_bg_enable || pix == 2'b00) ? 5'd0 : {1'b0, r_pal, pix};
        color_idx = r_palette[pal_idx];
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_out_load = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                if (!clear_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (vreq.rd) begin
                    n_state = ST_TILE;
                end
            end
            ST_TILE: begin
                n_state = ST_SHADE;
            end
            ST_SHADE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_out_valid  <= 1'b0;
            r_scroll_h   <= '0;
            r_scroll_v   <= '0;
            r_base_table <= '0;
            r_pattern_hi <= 1'b0;
            r_bg_enable  <= 1'b0;
            for (int i = 0; i < PAL_DEPTH; i++) begin
                r_palette[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (n_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCROLL_H:   r_scroll_h   <= i_cfg_data;
                    CFG_SCROLL_V:   r_scroll_v   <= i_cfg_data;
                    CFG_BASE_TABLE: r_base_table <= i_cfg_data[1:0];
                    CFG_PATTERN_HI: r_pattern_hi <= i_cfg_data[0];
                    CFG_BG_ENABLE:  r_bg_enable  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (pal_we) begin
                r_palette[pal_waddr] <= i_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vreq.rd) begin
            r_fx     <= px[2:0];
            r_fy     <= py[2:0];
            r_row_b1 <= row[1];
            r_col_b1 <= px[4];
        end
        if (r_state == ST_TILE) begin
            r_pal <= attr_q[shift +: 2];
        end
        if (n_out_load) begin
            r_color_index <= color_idx;
            r_color_argb  <= master_argb(color_idx);
        end
    end

    trb_vram u_vram (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (vreq),
        .o_tile       (name_q),
        .o_attr       (attr_q),
        .o_clear_busy (clear_busy)
    );

    trb_pattern u_pattern (
        .i_clk    (i_clk),
        .i_we     (accept && (op == OP_PATLOAD)),
        .i_waddr  (i_address),
        .i_wdata  (i_data),
        .i_re     (r_state == ST_TILE),
        .i_tile   (tile),
        .i_fy     (r_fy),
        .o_plane0 (plane0_q),
        .o_plane1 (plane1_q)
    );

    assign o_out_valid   = r_out_valid;
    assign o_color_index = r_color_index;
    assign o_color_argb  = r_color_argb;

endmodule

`default_nettype wire

>>> src/trb_checker.sv
// Port-level checks for the tile background renderer, bound to the top level.
// Depends on trb_pkg.
`default_nettype none

module trb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic [1:0]                    i_opcode,
    input wire logic [7:0]                    i_pixel_y,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall
);
    import trb_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // clearing pass follows reset
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // a write or load produces no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode != OP_PIXEL) && !o_out_valid
        |=> !o_out_valid)
        else $error("result without pixel request");

    // a visible pixel occupies the pipeline
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_opcode == OP_PIXEL)
        && ({1'b0, i_pixel_y} < 9'(SCREEN_HEIGHT)) |=> o_in_stall)
        else $error("pixel transaction overlapped");

endmodule

bind tile_background_pixel_renderer_core trb_checker u_trb_checker (.*);

`default_nettype wire

>>> sim/tb_tile_background_pixel_renderer_core.sv
// Self-checking bench for the tile background pixel renderer core.
// Drives video writes, pattern loads and pixel requests and checks every colour against
// a behavioural shading model held here or a value given in the directed rows; needs trb_pkg and the core.
module tb_tile_background_pixel_renderer_core;
    timeunit 1ns;
    timeprecision 1ps;

    import trb_pkg::t_opcode;
    import trb_pkg::OP_VWRITE;
    import trb_pkg::OP_PATLOAD;
    import trb_pkg::OP_PIXEL;
    import trb_pkg::OP_NONE;
    import trb_pkg::CFG_IDX_W;
    import trb_pkg::CFG_SCROLL_H;
    import trb_pkg::CFG_SCROLL_V;
    import trb_pkg::CFG_BASE_TABLE;
    import trb_pkg::CFG_PATTERN_HI;
    import trb_pkg::CFG_BG_ENABLE;

    localparam int PATTERN_LEN     = 8192;
    localparam int TABLE_CELLS     = 960;
    localparam int ATTR_SPAN       = 64;
    localparam int ROWS_OF_TILES   = 30;
    localparam int VISIBLE_ROWS    = 240;
    localparam bit [7:0] BLANK_TILE = 8'h24;

    // name bytes are drawn from these tiles; both halves of each are loaded up front
    localparam int FILL_COUNT      = 5;
    localparam bit [7:0] FILL_TILES [FILL_COUNT] = '{8'h24, 8'hFF, 8'h01, 8'h00, 8'h80};

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 8;

    localparam bit [31:0] MASTER_ARGB [64] = '{
        32'hFF545454, 32'hFF001E74, 32'hFF081090, 32'hFF300088,
        32'hFF440064, 32'hFF5C0030, 32'hFF540400, 32'hFF3C1800,
        32'hFF202A00, 32'hFF083A00, 32'hFF004000, 32'hFF003C00,
        32'hFF00323C, 32'hFF000000, 32'hFF000000, 32'hFF000000,
        32'hFF989698, 32'hFF084CC4, 32'hFF3032EC, 32'hFF5C1EE4,
        32'hFF8814B0, 32'hFFA01464, 32'hFF982220, 32'hFF783C00,
        32'hFF545A00, 32'hFF287200, 32'hFF087C00, 32'hFF007628,
        32'hFF006678, 32'hFF000000, 32'hFF000000, 32'hFF000000,
        32'hFFECEEEC, 32'hFF4C9AEC, 32'hFF7080EC, 32'hFFA06CEC,
        32'hFFD060EC, 32'hFFEC60C0, 32'hFFEC7274, 32'hFFCC8C38,
        32'hFFB09C18, 32'hFF7CB010, 32'hFF4CC034, 32'hFF38C878,
        32'hFF38B4CC, 32'hFF3C3C3C, 32'hFF000000, 32'hFF000000,
        32'hFFECEEEC, 32'hFFA8CCEC, 32'hFFBCBCEC, 32'hFFD4B2EC,
        32'hFFECAEEC, 32'hFFECAED4, 32'hFFECB4B0, 32'hFFE4C490,
        32'hFFCCD278, 32'hFFB4DE78, 32'hFFA8E290, 32'hFF98E2B4,
        32'hFFA0D6E4, 32'hFFA0A2A0, 32'hFF000000, 32'hFF000000
    };

    typedef struct {
        t_opcode   op;
        bit [13:0] addr;
        bit [7:0]  data;
        bit [7:0]  x;
        bit [7:0]  y;
    } t_req;

    typedef struct {
        bit [5:0]  color_code;
        bit [31:0] argb;
    } t_shade;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        bit [7:0]             cfg_val;
        t_req                 req;
        bit                   typed;
        t_shade               typed_shade;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_opcode = '0;
    logic [13:0]          i_address = '0;
    logic [7:0]           i_data = '0;
    logic [7:0]           i_pixel_x = '0;
    logic [7:0]           i_pixel_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [5:0]           o_color_index;
    logic [31:0]          o_color_argb;

    // shading model state
    bit [7:0] pat_mem  [PATTERN_LEN];
    bit [7:0] name_mem [2*TABLE_CELLS];
    bit [7:0] attr_mem [2*ATTR_SPAN];
    bit [5:0] pal_mem  [32];
    bit [7:0] scroll_h, scroll_v;
    bit [1:0] base_sel;
    bit       pat_hi, bg_on;

    t_shade pending_shades [$];
    t_row   directed_rows [$];

    bit long_hold = 1'b0;
    bit no_idle = 1'b0;
    int fail_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;

    tile_background_pixel_renderer_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_address     (i_address),
        .i_data        (i_data),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_color_index (o_color_index),
        .o_color_argb  (o_color_argb)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 16);
    endfunction

    function automatic void store_video(input bit [13:0] addr, input bit [7:0] data);
        int a, phys, off, slot;
        if (addr >= 14'h2000 && addr <= 14'h2FFF) begin
            a = int'(addr) & 'hFFF;
            phys = a >> 11;
            off = a & 'h3FF;
            if (off < TABLE_CELLS) name_mem[phys * TABLE_CELLS + off] = data;
            else attr_mem[phys * ATTR_SPAN + off - TABLE_CELLS] = data;
        end else if (addr >= 14'h3F00 && addr <= 14'h3F1F) begin
            slot = int'(addr) & 'h1F;
            // sprite backdrop entries fold onto the background ones
            if (slot >= 16 && (slot & 3) == 0) slot -= 16;
            pal_mem[slot] = data[5:0];
        end
    endfunction

    function automatic bit [5:0] shade_pixel(input bit [7:0] x, input bit [7:0] y);
        int px, py, col, row, fx, fy, nt, phys, tile, pal, pix;
        bit [7:0] attr, plane0, plane1;
        if (!bg_on) return pal_mem[0];
        px = int'(x) + int'(scroll_h);
        py = int'(y) + int'(scroll_v);
        col = (px / 8) % 32;
        row = (py / 8) % ROWS_OF_TILES;
        fx = px % 8;
        fy = py % 8;
        nt = int'(base_sel);
        if (px / 8 >= 32) nt = nt ^ 1;
        if (py / 8 >= ROWS_OF_TILES) nt = nt ^ 2;
        // horizontal mirroring: logical tables pair up onto one physical table
        phys = nt / 2;
        tile = int'(name_mem[phys * TABLE_CELLS + row * 32 + col]);
        attr = attr_mem[phys * ATTR_SPAN + (row / 4) * 8 + col / 4];
        pal = (int'(attr) >> ((row / 2 % 2) * 4 + (col / 2 % 2) * 2)) & 3;
        if (pat_hi) tile += 256;
        plane0 = pat_mem[tile * 16 + fy];
        plane1 = pat_mem[tile * 16 + fy + 8];
        pix = {plane1[7 - fx], plane0[7 - fx]};
        if (pix == 0) return pal_mem[0];
        return pal_mem[pal * 4 + pix];
    endfunction

    function automatic t_req random_req(input bit pixels_only);
        t_req r;
        int pick, lane;
        r.op = OP_NONE;
        r.addr = 14'($urandom_range(0, 16383));
        r.data = 8'($urandom_range(0, 255));
        r.x = 8'($urandom_range(0, 255));
        r.y = 8'($urandom_range(0, VISIBLE_ROWS - 1));
        pick = pixels_only ? 60 : $urandom_range(0, 99);
        if (pick < 30) begin
            r.op = OP_VWRITE;
            lane = $urandom_range(0, 9);
            if (lane < 5) r.addr = 14'('h2000 + $urandom_range(0, 'hFFF));
            else if (lane < 7)
                r.addr = 14'('h2000 + $urandom_range(0, 3) * 1024 + $urandom_range(960, 1023));
            else if (lane < 9) r.addr = 14'('h3F00 + $urandom_range(0, 31));
            // keep name bytes on tiles whose pattern rows are loaded
            if (r.addr[13:12] == 2'b10 && r.addr[9:0] < 10'(TABLE_CELLS))
                r.data = FILL_TILES[$urandom_range(0, FILL_COUNT - 1)];
        end else if (pick < 45) begin
            r.op = OP_PATLOAD;
            if ($urandom_range(0, 7) != 0) r.addr = 14'($urandom_range(0, PATTERN_LEN - 1));
        end else if (pick < 95) begin
            r.op = OP_PIXEL;
            if ($urandom_range(0, 15) == 0) r.y = 8'($urandom_range(VISIBLE_ROWS, 255));
        end
        return r;
    endfunction

    function automatic t_row item_row(input t_opcode op, input bit [13:0] addr,
                                      input bit [7:0] data, input bit [7:0] x,
                                      input bit [7:0] y);
        t_row row;
        row.is_cfg = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.req.op = op;
        row.req.addr = addr;
        row.req.data = data;
        row.req.x = x;
        row.req.y = y;
        row.typed = 1'b0;
        row.typed_shade.color_code = '0;
        row.typed_shade.argb = '0;
        return row;
    endfunction

    function automatic t_row checked_pixel(input bit [7:0] x, input bit [7:0] y,
                                           input bit [5:0] idx, input bit [31:0] argb);
        t_row row;
        row = item_row(OP_PIXEL, 14'h3FFF, 8'hFF, x, y);
        row.typed = 1'b1;
        row.typed_shade.color_code = idx;
        row.typed_shade.argb = argb;
        return row;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] val);
        t_row row;
        row = item_row(OP_NONE, '0, '0, '0, '0);
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        return row;
    endfunction

    task automatic send_request(input t_req r, input bit typed, input t_shade typed_shade);
        int gap;
        t_shade s;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= r.op;
        i_address <= r.addr;
        i_data <= r.data;
        i_pixel_x <= r.x;
        i_pixel_y <= r.y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        case (r.op)
            OP_VWRITE: store_video(r.addr, r.data);
            OP_PATLOAD: if (r.addr < PATTERN_LEN) pat_mem[r.addr] = r.data;
            OP_PIXEL: begin
                // every column is on screen; only rows past the bottom are dropped
                if (r.y < VISIBLE_ROWS) begin
                    if (typed) begin
                        s = typed_shade;
                    end else begin
                        s.color_code = shade_pixel(r.x, r.y);
                        s.argb = MASTER_ARGB[s.color_code];
                    end
                    pending_shades.push_back(s);
                end
            end
            default: ;
        endcase
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_SCROLL_H: scroll_h = val;
            CFG_SCROLL_V: scroll_v = val;
            CFG_BASE_TABLE: base_sel = val[1:0];
            CFG_PATTERN_HI: pat_hi = val[0];
            CFG_BG_ENABLE: bg_on = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // result side: random back-pressure, plus one long hold-off on request
    initial begin : result_sink
        int wait_cycles;
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            wait_cycles = draw_gap();
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_shade s;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_shades.size() == 0) begin
                $display("%0t: unexpected pixel result, expected none, got index %0d argb %h",
                         $time, o_color_index, o_color_argb);
                fail_count++;
            end else begin
                s = pending_shades.pop_front();
                results_checked++;
                if (o_color_index !== s.color_code) begin
                    $display("%0t: colour index mismatch, expected %0d, got %0d",
                             $time, s.color_code, o_color_index);
                    fail_count++;
                end
                if (o_color_argb !== s.argb) begin
                    $display("%0t: argb mismatch, expected %h, got %h",
                             $time, s.argb, o_color_argb);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row row;
        t_req r;
        t_shade no_shade;
        bit [7:0] h, v;
        bit [1:0] b;
        bit hi, en;

        no_shade.color_code = '0;
        no_shade.argb = '0;
        foreach (name_mem[i]) name_mem[i] = BLANK_TILE;
        foreach (attr_mem[i]) attr_mem[i] = '0;
        foreach (pal_mem[i]) pal_mem[i] = '0;
        foreach (pat_mem[i]) pat_mem[i] = '0;
        scroll_h = '0;
        scroll_v = '0;
        base_sel = '0;
        pat_hi = 1'b0;
        bg_on = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load both halves of every tile a name byte can hold, so no pixel reads
        // an unwritten pattern byte
        foreach (FILL_TILES[t]) begin
            for (int half = 0; half < 2; half++) begin
                for (int k = 0; k < 16; k++) begin
                    r = random_req(1'b0);
                    r.op = OP_PATLOAD;
                    r.addr = 14'((half * 256 + int'(FILL_TILES[t])) * 16 + k);
                    send_request(r, 1'b0, no_shade);
                end
            end
        end

        // background off after reset: everything is the universal colour
        directed_rows.push_back(checked_pixel(8'd0, 8'd0, 6'h00, 32'hFF545454));
        directed_rows.push_back(checked_pixel(8'd255, 8'd239, 6'h00, 32'hFF545454));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd0, 8'd240));
        directed_rows.push_back(item_row(OP_NONE, 14'h3FFF, 8'hFF, 8'hFF, 8'hFF));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h3F00, 8'hFF, 8'd0, 8'd0));
        directed_rows.push_back(checked_pixel(8'd128, 8'd100, 6'h3F, 32'hFF000000));
        // backdrop mirror entry lands on entry zero
        directed_rows.push_back(item_row(OP_VWRITE, 14'h3F10, 8'h21, 8'd0, 8'd0));
        directed_rows.push_back(checked_pixel(8'd7, 8'd8, 6'h21, 32'hFF4C9AEC));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h3F1F, 8'h30, 8'd0, 8'd0));
        // writes outside both windows and an out-of-range pattern load are dropped
        directed_rows.push_back(item_row(OP_VWRITE, 14'h3FFF, 8'h00, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h1FFF, 8'h00, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h3000, 8'h00, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_PATLOAD, 14'h3FFF, 8'hAA, 8'd0, 8'd0));
        directed_rows.push_back(checked_pixel(8'd0, 8'd0, 6'h21, 32'hFF4C9AEC));
        directed_rows.push_back(cfg_row(CFG_BG_ENABLE, 8'h01));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h2000, 8'hFF, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h23C0, 8'hE4, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h2BFF, 8'h80, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_VWRITE, 14'h2FBF, 8'h01, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_PATLOAD, 14'h0FF0, 8'h81, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd255, 8'd239));
        directed_rows.push_back(cfg_row(CFG_SCROLL_H, 8'hFF));
        directed_rows.push_back(cfg_row(CFG_SCROLL_V, 8'hFF));
        directed_rows.push_back(cfg_row(CFG_BASE_TABLE, 8'h03));
        directed_rows.push_back(cfg_row(CFG_PATTERN_HI, 8'h01));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd0, 8'd0));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd255, 8'd239));
        directed_rows.push_back(item_row(OP_PIXEL, 14'h0000, 8'h00, 8'd1, 8'd1));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                settle();
                write_reg(row.cfg_idx, row.cfg_val);
            end else begin
                send_request(row.req, row.typed, row.typed_shade);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            h = 8'($urandom_range(0, 255));
            v = 8'($urandom_range(0, 255));
            b = 2'($urandom_range(0, 3));
            hi = 1'($urandom_range(0, 1));
            en = 1'b1;
            if (phase == 0) begin
                h = 8'hFF;
                v = 8'hFF;
                b = 2'd3;
                hi = 1'b1;
            end
            if (phase == 1) begin
                h = 8'h00;
                v = 8'h00;
                b = 2'd0;
                hi = 1'b0;
            end
            if (phase == 2) en = 1'b0;
            // upper data bits of the narrow registers carry noise
            write_reg(CFG_SCROLL_H, h);
            write_reg(CFG_SCROLL_V, v);
            write_reg(CFG_BASE_TABLE, {6'($urandom), b});
            write_reg(CFG_PATTERN_HI, {7'($urandom), hi});
            write_reg(CFG_BG_ENABLE, {7'($urandom), en});
            write_reg(CFG_IDX_W'(5 + phase % 3), 8'($urandom));
            no_idle = (phase == 4);
            if (phase == 3) long_hold = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = random_req(phase == 3 && n < 50);
                send_request(r, 1'b0, no_shade);
            end
        end

        settle();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d transactions (pattern rows of the tiles in use, %0d directed rows, %0d random phases)",
                 items_sent, directed_rows.size(), PHASES);
        $display("Compared %0d pixel results over %0d register writes", results_checked,
                 reg_writes);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
